/* sv/rabf_pkg.sv */
package rabf_pkg;

  localparam int MAX_DIM = 4096;

  localparam int COORD_W = 12;
  localparam int RECT_W  = 13;
  localparam int FILL_W  = 32;

  // APB port
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 5;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_LEFT   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_TOP    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FILL   = 3'd4;

  // Channels: 0 red, 1 green, 2 blue, 3 alpha
  localparam int CH_W   = 8;
  localparam int CH_ALL = 4;
  localparam int CH_N   = 3;
  localparam int CH_A   = 3;

  localparam logic [CH_W-1:0] ALPHA_MAX = 8'hFF;

  // Datapath widths
  localparam int PROD_W = 2 * CH_W;     // 8x8 products
  localparam int OAX_W  = PROD_W + 1;   // alpha numerator plus rounding headroom
  localparam int NUM_W  = 24;           // channel numerator, at most 255*65025
  localparam int DIV_W  = PROD_W;       // 255 * out alpha
  localparam int QUOT_W = 9;            // quotient stays below 510

  localparam int FRONT_STAGES = 2;
  localparam int NSTAGES      = FRONT_STAGES + QUOT_W + 1;

  typedef logic [CH_ALL-1:0][CH_W-1:0]  pix_t;
  typedef logic [CH_N-1:0][NUM_W-1:0]   num_vec_t;
  typedef logic [CH_N-1:0][QUOT_W-1:0]  quot_vec_t;

  typedef struct packed {
    logic signed [RECT_W-1:0] left;
    logic signed [RECT_W-1:0] top;
    logic [RECT_W-1:0]        width;
    logic [RECT_W-1:0]        height;
    logic [FILL_W-1:0]        fill;
  } rect_cfg_t;

  typedef struct packed {
    logic            cov;
    logic [CH_W-1:0] oa;
    pix_t            dst;
  } side_t;

endpackage

/* sv/rabf_front.sv */
module rabf_front (
  input  logic                         clk_i,
  input  logic [1:0]                   en_i,
  input  rabf_pkg::rect_cfg_t          cfg_i,
  input  logic [rabf_pkg::COORD_W-1:0] col_i,
  input  logic [rabf_pkg::COORD_W-1:0] row_i,
  input  rabf_pkg::pix_t               dst_i,
  output rabf_pkg::side_t              side_o,
  output rabf_pkg::num_vec_t           num_o
);
  import rabf_pkg::*;

  localparam int EDGE_W = RECT_W + 2;

  // stage A: rectangle test and 8x8 products
  logic signed [EDGE_W-1:0]    left_x, top_x, right_x, bottom_x, col_x, row_x;
  logic                        inside_a;
  logic [CH_W-1:0]             alpha, inv_alpha;
  logic [PROD_W-1:0]           m_a;
  logic [CH_N-1:0][PROD_W-1:0] ac_a;

  logic                        cov_a_q;
  logic [PROD_W-1:0]           m_a_q;
  logic [CH_N-1:0][PROD_W-1:0] ac_a_q;
  pix_t                        dst_a_q;

  // stage B: out alpha and channel numerators
  logic [OAX_W-1:0] x_b, oa_b;
  num_vec_t         num_b;
  side_t            side_q;
  num_vec_t         num_q;

  always_comb begin
    left_x   = EDGE_W'(cfg_i.left);
    top_x    = EDGE_W'(cfg_i.top);
    right_x  = left_x + $signed(EDGE_W'(cfg_i.width));
    bottom_x = top_x + $signed(EDGE_W'(cfg_i.height));
    col_x    = $signed(EDGE_W'(col_i));
    row_x    = $signed(EDGE_W'(row_i));
    inside_a = (col_x >= left_x) && (col_x < right_x) &&
               (row_x >= top_x) && (row_x < bottom_x) &&
               (32'(col_i) < MAX_DIM) && (32'(row_i) < MAX_DIM);

    alpha     = cfg_i.fill[CH_W-1:0];
    inv_alpha = ALPHA_MAX - alpha;
    m_a       = PROD_W'(dst_i[CH_A]) * PROD_W'(inv_alpha);
    for (int c = 0; c < CH_N; c++) begin
      ac_a[c] = PROD_W'(cfg_i.fill[CH_W*(CH_ALL-1-c) +: CH_W]) * PROD_W'(alpha);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      cov_a_q <= inside_a;
      m_a_q   <= m_a;
      ac_a_q  <= ac_a;
      dst_a_q <= dst_i;
    end
  end

  always_comb begin
    x_b  = OAX_W'({alpha, 8'h00}) - OAX_W'(alpha) + OAX_W'(m_a_q);
    // exact x/255 for x below 65535
    oa_b = (x_b + (x_b >> 8) + OAX_W'(1)) >> 8;
    for (int c = 0; c < CH_N; c++) begin
      num_b[c] = NUM_W'({ac_a_q[c], 8'h00}) - NUM_W'(ac_a_q[c]) +
                 NUM_W'(dst_a_q[c]) * NUM_W'(m_a_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      side_q.cov <= cov_a_q;
      side_q.oa  <= oa_b[CH_W-1:0];
      side_q.dst <= dst_a_q;
      num_q      <= num_b;
    end
  end

  assign side_o = side_q;
  assign num_o  = num_q;

endmodule

/* sv/rabf_div.sv */
module rabf_div (
  input  logic                        clk_i,
  input  logic [rabf_pkg::QUOT_W-1:0] en_i,
  input  rabf_pkg::side_t             side_i,
  input  rabf_pkg::num_vec_t          num_i,
  output rabf_pkg::side_t             side_o,
  output rabf_pkg::quot_vec_t         quot_o
);
  import rabf_pkg::*;

  // restoring divide, one quotient bit per stage, msb first
  side_t            side_q [QUOT_W];
  logic [DIV_W-1:0] d_q    [QUOT_W];
  num_vec_t         rem_q  [QUOT_W];
  quot_vec_t        quo_q  [QUOT_W];

  for (genvar s = 0; s < QUOT_W; s++) begin : g_stage
    localparam int B = QUOT_W - 1 - s;

    side_t            side_in;
    logic [DIV_W-1:0] d_in;
    num_vec_t         rem_in, rem_out;
    quot_vec_t        quo_in, quo_out;
    logic [NUM_W:0]   trial [CH_N];

    if (s == 0) begin : g_head
      always_comb begin
        side_in = side_i;
        d_in    = DIV_W'({side_i.oa, 8'h00}) - DIV_W'(side_i.oa);
        rem_in  = num_i;
        quo_in  = '0;
      end
    end else begin : g_body
      always_comb begin
        side_in = side_q[s-1];
        d_in    = d_q[s-1];
        rem_in  = rem_q[s-1];
        quo_in  = quo_q[s-1];
      end
    end

    always_comb begin
      for (int c = 0; c < CH_N; c++) begin
        trial[c] = {1'b0, rem_in[c]} - ((NUM_W + 1)'(d_in) << B);
        quo_out[c] = quo_in[c];
        if (!trial[c][NUM_W]) begin
          rem_out[c]    = trial[c][NUM_W-1:0];
          quo_out[c][B] = 1'b1;
        end else begin
          rem_out[c] = rem_in[c];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        side_q[s] <= side_in;
        d_q[s]    <= d_in;
        rem_q[s]  <= rem_out;
        quo_q[s]  <= quo_out;
      end
    end
  end

  assign side_o = side_q[QUOT_W-1];
  assign quot_o = quo_q[QUOT_W-1];

endmodule

/* sv/rect_alpha_blend_fill_unit.sv */
// 12 register stages from the accepting edge to out_valid_o. Throughput: one item
// per cycle while the output is not stalled; the channel divide is a 9-stage
// restoring divider, one quotient bit per stage, so no stage iterates on one item.
// Output stalls collapse bubbles; items keep entering while results wait until full.
// Reset (rst_ni low, asynchronous) clears all valid bits and the config registers.
module rect_alpha_blend_fill_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rabf_pkg::ADDR_W-1:0]   paddr,
  input  logic [rabf_pkg::DATA_W-1:0]   pwdata,
  output logic [rabf_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,

  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [rabf_pkg::COORD_W-1:0]  pixel_col_i,
  input  logic [rabf_pkg::COORD_W-1:0]  pixel_row_i,
  input  logic [rabf_pkg::CH_W-1:0]     dst_red_i,
  input  logic [rabf_pkg::CH_W-1:0]     dst_green_i,
  input  logic [rabf_pkg::CH_W-1:0]     dst_blue_i,
  input  logic [rabf_pkg::CH_W-1:0]     dst_alpha_i,

  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rabf_pkg::CH_W-1:0]     out_red_o,
  output logic [rabf_pkg::CH_W-1:0]     out_green_o,
  output logic [rabf_pkg::CH_W-1:0]     out_blue_o,
  output logic [rabf_pkg::CH_W-1:0]     out_opacity_o,
  output logic                          covered_o
);
  import rabf_pkg::*;

  // config registers
  logic [RECT_W-1:0]    left_q, top_q, width_q, height_q;
  logic [FILL_W-1:0]    fill_q;
  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] cfg_idx;
  rect_cfg_t            cfg;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      top_q    <= '0;
      width_q  <= '0;
      height_q <= '0;
      fill_q   <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_LEFT:   left_q   <= pwdata[RECT_W-1:0];
        REG_TOP:    top_q    <= pwdata[RECT_W-1:0];
        REG_WIDTH:  width_q  <= pwdata[RECT_W-1:0];
        REG_HEIGHT: height_q <= pwdata[RECT_W-1:0];
        REG_FILL:   fill_q   <= pwdata[FILL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_LEFT:   prdata = DATA_W'(left_q);
      REG_TOP:    prdata = DATA_W'(top_q);
      REG_WIDTH:  prdata = DATA_W'(width_q);
      REG_HEIGHT: prdata = DATA_W'(height_q);
      REG_FILL:   prdata = DATA_W'(fill_q);
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    cfg.left   = left_q;
    cfg.top    = top_q;
    cfg.width  = width_q;
    cfg.height = height_q;
    cfg.fill   = fill_q;
  end

  // stage valids; a stage loads when it or any later stage is empty, or when out_ready_i is high
  logic [NSTAGES-1:0] vld_q, vld_d, en;

  for (genvar k = 0; k < NSTAGES; k++) begin : g_en
    assign en[k] = out_ready_i | ~(&vld_q[NSTAGES-1:k]);
  end

  always_comb begin
    vld_d[0] = en[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < NSTAGES; k++) begin
      vld_d[k] = en[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NSTAGES-1];

  // datapath
  pix_t      dst_in;
  side_t     side_f, side_v;
  num_vec_t  num_f;
  quot_vec_t quot_v;

  assign dst_in = {dst_alpha_i, dst_blue_i, dst_green_i, dst_red_i};

  rabf_front u_front (
    .clk_i  (clk_i),
    .en_i   (en[1:0]),
    .cfg_i  (cfg),
    .col_i  (pixel_col_i),
    .row_i  (pixel_row_i),
    .dst_i  (dst_in),
    .side_o (side_f),
    .num_o  (num_f)
  );

  rabf_div u_div (
    .clk_i  (clk_i),
    .en_i   (en[FRONT_STAGES +: QUOT_W]),
    .side_i (side_f),
    .num_i  (num_f),
    .side_o (side_v),
    .quot_o (quot_v)
  );

  // output register
  pix_t pix_d, pix_q;
  logic cov_q;

  always_comb begin
    if (!side_v.cov) begin
      pix_d = side_v.dst;
    end else if (side_v.oa == '0) begin
      pix_d = '0;
    end else begin
      for (int c = 0; c < CH_N; c++) begin
        pix_d[c] = quot_v[c][CH_W-1:0];
      end
      pix_d[CH_A] = side_v.oa;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NSTAGES-1]) begin
      pix_q <= pix_d;
      cov_q <= side_v.cov;
    end
  end

  assign out_red_o     = pix_q[0];
  assign out_green_o   = pix_q[1];
  assign out_blue_o    = pix_q[2];
  assign out_opacity_o = pix_q[CH_A];
  assign covered_o     = cov_q;

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output register");

  a_zero_alpha_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && covered_o && out_opacity_o == '0) |->
    (out_red_o == '0 && out_green_o == '0 && out_blue_o == '0))
    else $error("covered pixel with zero alpha has nonzero color");

  a_last_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NSTAGES-2] && en[NSTAGES-1]) |=> out_valid_o)
    else $error("item lost entering the output register");

endmodule
